/* rtl/joint_velocity_limiter_defines.svh */
// ----------------------------------------------------------------------------
// joint velocity limiter assertion macros
// shared property shapes for the limiter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef JOINT_VELOCITY_LIMITER_DEFINES_SVH
`define JOINT_VELOCITY_LIMITER_DEFINES_SVH

// same-cycle implication
`define JVL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define JVL_ASSERT_DLY(name, clk, rst_n, ante, dly, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

/* rtl/jvl_pkg.sv */
// ----------------------------------------------------------------------------
// jvl_pkg
// types, codes and joint limit constants of the joint velocity limiter
// ----------------------------------------------------------------------------
`default_nettype none

package jvl_pkg;

    localparam int NUM_JOINTS = 5;
    localparam int POS_W      = 20;
    localparam int VEL_W      = 20;
    localparam int MAG_W      = 19;  // quotient magnitude, never above max_velocity
    localparam int CFG_W      = 19;
    localparam int DIV_W      = 8;
    localparam int LIM_W      = 22;  // limits plus margins, signed
    localparam int CFG_IDX_W  = 3;
    localparam int JIDX_W     = 3;
    localparam int ACT_W      = 2;
    localparam int MUL_W      = VEL_W + CFG_W;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_MARGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_MARGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_DIVISOR = 3'd3;

    localparam logic [CFG_W-1:0] MAX_VELOCITY_RST = 19'd6554;
    localparam logic [CFG_W-1:0] SOFT_MARGIN_RST  = 19'd11438;
    localparam logic [CFG_W-1:0] HARD_MARGIN_RST  = 19'd2288;
    localparam logic [DIV_W-1:0] SOFT_DIVISOR_RST = 8'd10;

    // limit action codes
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SOFT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP = 2'd2;

    // joint angle limits, Q3.16
    localparam logic signed [LIM_W-1:0] LIM_MIN [NUM_JOINTS] =
        '{22'sd58, 22'sd5, -22'sd339556, 22'sd109, 22'sd61};
    localparam logic signed [LIM_W-1:0] LIM_MAX [NUM_JOINTS] =
        '{22'sd386371, 22'sd177296, -22'sd76, 22'sd233779, 22'sd382652};

    typedef struct packed {
        logic signed [POS_W-1:0] position_0;
        logic signed [POS_W-1:0] position_1;
        logic signed [POS_W-1:0] position_2;
        logic signed [POS_W-1:0] position_3;
        logic signed [POS_W-1:0] position_4;
        logic signed [VEL_W-1:0] speed_in_0;
        logic signed [VEL_W-1:0] speed_in_1;
        logic signed [VEL_W-1:0] speed_in_2;
        logic signed [VEL_W-1:0] speed_in_3;
        logic signed [VEL_W-1:0] speed_in_4;
    } t_jvl_in;

    typedef struct packed {
        logic signed [VEL_W-1:0] speed_out_0;
        logic signed [VEL_W-1:0] speed_out_1;
        logic signed [VEL_W-1:0] speed_out_2;
        logic signed [VEL_W-1:0] speed_out_3;
        logic signed [VEL_W-1:0] speed_out_4;
        logic                    was_normalized;
        logic [ACT_W-1:0]        limit_action;
        logic [JIDX_W-1:0]       limit_joint;
    } t_jvl_out;

    // position against the margins of one joint
    typedef struct packed {
        logic soft_lo;
        logic hard_lo;
        logic soft_hi;
        logic hard_hi;
    } t_pos_flags;

    // sideband through the normalizing divider
    typedef struct packed {
        logic [NUM_JOINTS-1:0]       neg;
        t_pos_flags [NUM_JOINTS-1:0] flags;
        logic                        normalized;
    } t_norm_tag;

    // sideband through the slowdown divider
    typedef struct packed {
        logic [NUM_JOINTS-1:0] neg;
        logic                  normalized;
        logic [ACT_W-1:0]      action;
        logic [JIDX_W-1:0]     joint;
    } t_soft_tag;

endpackage

`default_nettype wire

/* rtl/jvl_div_pipe.sv */
// ----------------------------------------------------------------------------
// jvl_div_pipe
// pipelined restoring divider, one quotient bit per stage, shared divisor
// across lanes; the top DEN_W dividend bits must be below the divisor
// ----------------------------------------------------------------------------
`default_nettype none

module jvl_div_pipe
    import jvl_pkg::*;
#(
    parameter int LANES = NUM_JOINTS,
    parameter int DEN_W = VEL_W,
    parameter int Q_W   = MAG_W,
    parameter int TAG_W = 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic [DEN_W-1:0]                    i_den,
    input  wire logic [LANES-1:0][DEN_W+Q_W-1:0]     i_num,
    input  wire logic [TAG_W-1:0]                    i_tag,
    output logic                                     o_valid,
    output logic [LANES-1:0][Q_W-1:0]                o_quot,
    output logic [TAG_W-1:0]                         o_tag
);

    localparam int NUM_W = DEN_W + Q_W;

    // working word per lane: remainder on top, dividend bits below,
    // quotient bits shifted in at the bottom
    logic [Q_W-1:0]                         r_valid;
    logic [Q_W-1:0][DEN_W-1:0]              r_den;
    logic [Q_W-1:0][TAG_W-1:0]              r_tag;
    logic [Q_W-1:0][LANES-1:0][NUM_W-1:0]   r_w;

    logic [Q_W-1:0]                         c_valid;
    logic [Q_W-1:0][DEN_W-1:0]              c_den;
    logic [Q_W-1:0][TAG_W-1:0]              c_tag;
    logic [Q_W-1:0][LANES-1:0][NUM_W-1:0]   c_w;
    logic [Q_W-1:0][LANES-1:0][NUM_W-1:0]   n_w;

    // stage k works on what stage k-1 holds, stage 0 on the input
    assign c_valid = {r_valid[Q_W-2:0], i_valid};
    assign c_den   = {r_den[Q_W-2:0], i_den};
    assign c_tag   = {r_tag[Q_W-2:0], i_tag};
    assign c_w     = {r_w[Q_W-2:0], i_num};

    always_comb begin
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        logic           ge;
        for (int k = 0; k < Q_W; k++) begin
            for (int l = 0; l < LANES; l++) begin
                t  = c_w[k][l][NUM_W-1:Q_W-1];
                ge = (t >= {1'b0, c_den[k]});
                d  = t - {1'b0, c_den[k]};
                n_w[k][l] = {(ge ? d[DEN_W-1:0] : t[DEN_W-1:0]),
                             c_w[k][l][Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= c_den;
        r_tag <= c_tag;
        r_w   <= n_w;
    end

    assign o_valid = r_valid[Q_W-1];
    assign o_tag   = r_tag[Q_W-1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quot[l] = r_w[Q_W-1][l][Q_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/joint_velocity_limiter.sv */
// ----------------------------------------------------------------------------
// joint_velocity_limiter
// clamps a five-joint velocity command to a speed limit and to the joint
// angle limits, with a soft slowdown zone and a hard stop zone
// ----------------------------------------------------------------------------
// usage
//   input: raise start for one cycle with the joint vector on i_in; busy is
//   never raised, so a new beat may follow in every cycle.
//   output: each beat gives exactly one result on o_res, marked by o_valid
//   for one cycle, in order. the receiver cannot stall; it takes o_res in
//   the cycle o_valid is high.
//   throughput: one beat per cycle. latency is set by the two bit-per-stage
//   dividers (19 stages each for the speed scaling and for the slowdown
//   divisor) plus six stages of compare, max, multiply and output logic.
//   config: i_cfg_we writes i_cfg_data to register i_cfg_idx at once
//   (0 max_velocity, 1 soft_margin, 2 hard_margin, 3 soft_divisor); other
//   indexes are ignored. write only while no beat is in flight.
//   reset: synchronous, active low; empties the pipeline and loads the
//   register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joint_velocity_limiter_defines.svh"

module joint_velocity_limiter
    import jvl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire t_jvl_in                i_in,
    output logic                        o_valid,
    output t_jvl_out                    o_res,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    localparam int NORM_TAG_W = $bits(t_norm_tag);
    localparam int SOFT_TAG_W = $bits(t_soft_tag);
    localparam int LATENCY    = 6 + 2 * MAG_W;

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0] r_max_velocity;
    logic [CFG_W-1:0] r_soft_margin;
    logic [CFG_W-1:0] r_hard_margin;
    logic [DIV_W-1:0] r_soft_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_velocity <= MAX_VELOCITY_RST;
            r_soft_margin  <= SOFT_MARGIN_RST;
            r_hard_margin  <= HARD_MARGIN_RST;
            r_soft_divisor <= SOFT_DIVISOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_VELOCITY: r_max_velocity <= i_cfg_data;
                CFG_SOFT_MARGIN:  r_soft_margin  <= i_cfg_data;
                CFG_HARD_MARGIN:  r_hard_margin  <= i_cfg_data;
                CFG_SOFT_DIVISOR: r_soft_divisor <= i_cfg_data[DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    // ------------------------------------------- stage 1: margins, magnitudes
    logic [NUM_JOINTS-1:0][POS_W-1:0] in_pos;
    logic [NUM_JOINTS-1:0][VEL_W-1:0] in_vel;

    assign in_pos[0] = i_in.position_0;
    assign in_pos[1] = i_in.position_1;
    assign in_pos[2] = i_in.position_2;
    assign in_pos[3] = i_in.position_3;
    assign in_pos[4] = i_in.position_4;
    assign in_vel[0] = i_in.speed_in_0;
    assign in_vel[1] = i_in.speed_in_1;
    assign in_vel[2] = i_in.speed_in_2;
    assign in_vel[3] = i_in.speed_in_3;
    assign in_vel[4] = i_in.speed_in_4;

    logic                             r_s1_valid;
    logic [NUM_JOINTS-1:0][VEL_W-1:0] r_s1_mag;
    logic [NUM_JOINTS-1:0]            r_s1_neg;
    t_pos_flags [NUM_JOINTS-1:0]      r_s1_flags;

    logic [NUM_JOINTS-1:0][VEL_W-1:0] n_s1_mag;
    logic [NUM_JOINTS-1:0]            n_s1_neg;
    t_pos_flags [NUM_JOINTS-1:0]      n_s1_flags;

    always_comb begin
        logic signed [LIM_W-1:0] pos;
        logic signed [LIM_W-1:0] soft_mg;
        logic signed [LIM_W-1:0] hard;
        soft_mg = LIM_W'(r_soft_margin);
        hard    = LIM_W'(r_hard_margin);
        for (int j = 0; j < NUM_JOINTS; j++) begin
            pos = LIM_W'(signed'(in_pos[j]));
            n_s1_flags[j].soft_lo = pos < (LIM_MIN[j] + soft_mg);
            n_s1_flags[j].hard_lo = pos < (LIM_MIN[j] + hard);
            n_s1_flags[j].soft_hi = pos > (LIM_MAX[j] - soft_mg);
            n_s1_flags[j].hard_hi = pos > (LIM_MAX[j] - hard);
            n_s1_neg[j] = in_vel[j][VEL_W-1];
            n_s1_mag[j] = in_vel[j][VEL_W-1] ? (~in_vel[j] + VEL_W'(1)) : in_vel[j];
        end
    end

    // ------------------------------------------- stages 2 and 3: largest speed
    logic                             r_s2_valid;
    logic [VEL_W-1:0]                 r_s2_max01;
    logic [VEL_W-1:0]                 r_s2_max23;
    logic [NUM_JOINTS-1:0][VEL_W-1:0] r_s2_mag;
    logic [NUM_JOINTS-1:0]            r_s2_neg;
    t_pos_flags [NUM_JOINTS-1:0]      r_s2_flags;

    logic                             r_s3_valid;
    logic [VEL_W-1:0]                 r_s3_largest;
    logic [NUM_JOINTS-1:0][VEL_W-1:0] r_s3_mag;
    logic [NUM_JOINTS-1:0]            r_s3_neg;
    t_pos_flags [NUM_JOINTS-1:0]      r_s3_flags;

    logic [VEL_W-1:0] s3_max03;

    assign s3_max03 = (r_s2_max01 >= r_s2_max23) ? r_s2_max01 : r_s2_max23;

    // ------------------------------------------- stage 4: scale products
    logic                             r_s4_valid;
    logic                             r_s4_norm;
    logic [VEL_W-1:0]                 r_s4_largest;
    logic [NUM_JOINTS-1:0][MUL_W-1:0] r_s4_prod;
    logic [NUM_JOINTS-1:0][VEL_W-1:0] r_s4_mag;
    logic [NUM_JOINTS-1:0]            r_s4_neg;
    t_pos_flags [NUM_JOINTS-1:0]      r_s4_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mag   <= n_s1_mag;
        r_s1_neg   <= n_s1_neg;
        r_s1_flags <= n_s1_flags;

        r_s2_max01 <= (r_s1_mag[0] >= r_s1_mag[1]) ? r_s1_mag[0] : r_s1_mag[1];
        r_s2_max23 <= (r_s1_mag[2] >= r_s1_mag[3]) ? r_s1_mag[2] : r_s1_mag[3];
        r_s2_mag   <= r_s1_mag;
        r_s2_neg   <= r_s1_neg;
        r_s2_flags <= r_s1_flags;

        r_s3_largest <= (s3_max03 >= r_s2_mag[4]) ? s3_max03 : r_s2_mag[4];
        r_s3_mag     <= r_s2_mag;
        r_s3_neg     <= r_s2_neg;
        r_s3_flags   <= r_s2_flags;

        for (int j = 0; j < NUM_JOINTS; j++) begin
            r_s4_prod[j] <= MUL_W'(r_s3_mag[j]) * MUL_W'(r_max_velocity);
        end
        r_s4_norm    <= r_s3_largest > VEL_W'(r_max_velocity);
        r_s4_largest <= r_s3_largest;
        r_s4_mag     <= r_s3_mag;
        r_s4_neg     <= r_s3_neg;
        r_s4_flags   <= r_s3_flags;
    end

    // ------------------------------------------- normalizing divider
    // without scaling the magnitude passes through as a divide by one
    logic [NUM_JOINTS-1:0][MUL_W-1:0] na_num;
    logic [VEL_W-1:0]                 na_den;
    t_norm_tag                        na_tag_in;
    logic                             na_valid;
    logic [NUM_JOINTS-1:0][MAG_W-1:0] na_quot;
    logic [NORM_TAG_W-1:0]            na_tag_raw;
    t_norm_tag                        na_tag;

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            na_num[j] = r_s4_norm ? r_s4_prod[j] : MUL_W'(r_s4_mag[j]);
        end
        na_den               = r_s4_norm ? r_s4_largest : VEL_W'(1);
        na_tag_in.neg        = r_s4_neg;
        na_tag_in.flags      = r_s4_flags;
        na_tag_in.normalized = r_s4_norm;
    end

    jvl_div_pipe #(
        .LANES (NUM_JOINTS),
        .DEN_W (VEL_W),
        .Q_W   (MAG_W),
        .TAG_W (NORM_TAG_W)
    ) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_valid),
        .i_den   (na_den),
        .i_num   (na_num),
        .i_tag   (na_tag_in),
        .o_valid (na_valid),
        .o_quot  (na_quot),
        .o_tag   (na_tag_raw)
    );

    assign na_tag = t_norm_tag'(na_tag_raw);

    // ------------------------------------------- limit check
    logic                             r_sc_valid;
    logic [NUM_JOINTS-1:0][MAG_W-1:0] r_sc_quot;
    logic [NUM_JOINTS-1:0]            r_sc_neg;
    logic                             r_sc_norm;
    logic [ACT_W-1:0]                 r_sc_action;
    logic [JIDX_W-1:0]                r_sc_joint;

    logic [ACT_W-1:0]  n_sc_action;
    logic [JIDX_W-1:0] n_sc_joint;

    // first joint near a limit and moving toward it decides
    always_comb begin
        logic found;
        logic moving;
        logic lo;
        logic hi;
        found       = 1'b0;
        n_sc_action = ACT_NONE;
        n_sc_joint  = '0;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            moving = na_quot[j] != '0;
            lo     = na_tag.flags[j].soft_lo && na_tag.neg[j] && moving;
            hi     = na_tag.flags[j].soft_hi && !na_tag.neg[j] && moving;
            if (!found && (lo || hi)) begin
                found       = 1'b1;
                n_sc_joint  = JIDX_W'(j);
                n_sc_action = (lo ? na_tag.flags[j].hard_lo : na_tag.flags[j].hard_hi)
                              ? ACT_STOP : ACT_SOFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_valid <= 1'b0;
        end else begin
            r_sc_valid <= na_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sc_quot   <= na_quot;
        r_sc_neg    <= na_tag.neg;
        r_sc_norm   <= na_tag.normalized;
        r_sc_action <= n_sc_action;
        r_sc_joint  <= n_sc_joint;
    end

    // ------------------------------------------- slowdown divider
    // a zero divisor counts as one
    logic [NUM_JOINTS-1:0][DIV_W+MAG_W-1:0] sd_num;
    logic [DIV_W-1:0]                       sd_den;
    t_soft_tag                              sd_tag_in;
    logic                                   sd_valid;
    logic [NUM_JOINTS-1:0][MAG_W-1:0]       sd_quot;
    logic [SOFT_TAG_W-1:0]                  sd_tag_raw;
    t_soft_tag                              sd_tag;

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            sd_num[j] = (DIV_W + MAG_W)'(r_sc_quot[j]);
        end
        sd_den = (r_sc_action == ACT_SOFT && r_soft_divisor != '0)
                 ? r_soft_divisor : DIV_W'(1);
        sd_tag_in.neg        = r_sc_neg;
        sd_tag_in.normalized = r_sc_norm;
        sd_tag_in.action     = r_sc_action;
        sd_tag_in.joint      = r_sc_joint;
    end

    jvl_div_pipe #(
        .LANES (NUM_JOINTS),
        .DEN_W (DIV_W),
        .Q_W   (MAG_W),
        .TAG_W (SOFT_TAG_W)
    ) u_div_soft (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sc_valid),
        .i_den   (sd_den),
        .i_num   (sd_num),
        .i_tag   (sd_tag_in),
        .o_valid (sd_valid),
        .o_quot  (sd_quot),
        .o_tag   (sd_tag_raw)
    );

    assign sd_tag = t_soft_tag'(sd_tag_raw);

    // ------------------------------------------- output register
    logic                             r_out_valid;
    t_jvl_out                         r_out;
    t_jvl_out                         n_out;
    logic [NUM_JOINTS-1:0][VEL_W-1:0] out_spd;

    always_comb begin
        logic [VEL_W-1:0] m;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            m = VEL_W'(sd_quot[j]);
            if (sd_tag.action == ACT_STOP) begin
                out_spd[j] = '0;
            end else if (sd_tag.neg[j]) begin
                out_spd[j] = ~m + VEL_W'(1);
            end else begin
                out_spd[j] = m;
            end
        end
        n_out.speed_out_0    = out_spd[0];
        n_out.speed_out_1    = out_spd[1];
        n_out.speed_out_2    = out_spd[2];
        n_out.speed_out_3    = out_spd[3];
        n_out.speed_out_4    = out_spd[4];
        n_out.was_normalized = sd_tag.normalized;
        n_out.limit_action   = sd_tag.action;
        n_out.limit_joint    = sd_tag.joint;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= sd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // ------------------------------------------- assertions
    logic in_beat;
    logic out_stop;
    logic out_zero;
    logic out_idle;
    logic out_joint_zero;

    assign in_beat        = start && !busy;
    assign out_stop       = o_valid && (o_res.limit_action == ACT_STOP);
    assign out_zero       = (o_res.speed_out_0 == '0) && (o_res.speed_out_1 == '0) &&
                            (o_res.speed_out_2 == '0) && (o_res.speed_out_3 == '0) &&
                            (o_res.speed_out_4 == '0);
    assign out_idle       = o_valid && (o_res.limit_action == ACT_NONE);
    assign out_joint_zero = o_res.limit_joint == '0;

    `JVL_ASSERT_DLY(a_fixed_latency, i_clk, i_rst_n, in_beat, LATENCY, o_valid, "beat missing")
    `JVL_ASSERT_IMP(a_stop_zero, i_clk, i_rst_n, out_stop, out_zero, "stop with nonzero speed")
    `JVL_ASSERT_IMP(a_idle_joint, i_clk, i_rst_n, out_idle, out_joint_zero, "stray joint index")

endmodule

`default_nettype wire
